// ----- hdl/sc2a_pkg.sv -----
// sc2a_pkg: shared types, status codes and the scancode key map for the
// scancode-to-ASCII ring. No dependencies.
package sc2a_pkg;

    localparam int unsigned RING_DEPTH_DEFAULT = 256;
    localparam int unsigned CHAR_W             = 7;
    localparam int unsigned CODE_W             = 8;
    localparam int unsigned STATUS_W           = 3;

    // Special scancodes
    localparam logic [CODE_W-1:0] CODE_KP_ALT_A   = 8'h57;
    localparam logic [CODE_W-1:0] CODE_KP_ALT_B   = 8'h73;
    localparam logic [CODE_W-1:0] CODE_SPACE      = 8'h39;
    localparam logic [CODE_W-1:0] CODE_SLASH_KEY  = 8'h35;
    localparam logic [CODE_W-1:0] CODE_ENTER      = 8'h1C;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE  = 8'h0E;

    localparam logic [CHAR_W-1:0] CHAR_NONE      = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 7'h08;

    localparam logic OP_SCANCODE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [CODE_W-1:0] scancode;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   character;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

    // Lower-case key map; everything unlisted (incl. past the 76-entry map) is zero.
    function automatic logic [CHAR_W-1:0] key_lookup(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            8'd2:    ch = 7'h31;
            8'd3:    ch = 7'h32;
            8'd4:    ch = 7'h33;
            8'd5:    ch = 7'h34;
            8'd6:    ch = 7'h35;
            8'd7:    ch = 7'h36;
            8'd8:    ch = 7'h37;
            8'd9:    ch = 7'h38;
            8'd10:   ch = 7'h39;
            8'd11:   ch = 7'h30;
            8'd12:   ch = 7'h2D;
            8'd13:   ch = 7'h3D;
            8'd16:   ch = 7'h71;
            8'd17:   ch = 7'h77;
            8'd18:   ch = 7'h65;
            8'd19:   ch = 7'h72;
            8'd20:   ch = 7'h74;
            8'd21:   ch = 7'h79;
            8'd22:   ch = 7'h75;
            8'd23:   ch = 7'h69;
            8'd24:   ch = 7'h6F;
            8'd25:   ch = 7'h70;
            8'd27:   ch = 7'h5B;
            8'd30:   ch = 7'h61;
            8'd31:   ch = 7'h73;
            8'd32:   ch = 7'h64;
            8'd33:   ch = 7'h66;
            8'd34:   ch = 7'h67;
            8'd35:   ch = 7'h68;
            8'd36:   ch = 7'h6A;
            8'd37:   ch = 7'h6B;
            8'd38:   ch = 7'h6C;
            8'd39:   ch = 7'h3B;
            8'd41:   ch = 7'h5D;
            8'd43:   ch = 7'h5C;
            8'd44:   ch = 7'h7A;
            8'd45:   ch = 7'h78;
            8'd46:   ch = 7'h63;
            8'd47:   ch = 7'h76;
            8'd48:   ch = 7'h62;
            8'd49:   ch = 7'h6E;
            8'd50:   ch = 7'h6D;
            8'd51:   ch = 7'h2C;
            8'd52:   ch = 7'h2E;
            8'd53:   ch = 7'h3B;
            8'd56:   ch = 7'h20;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/sc2a_decode.sv -----
// sc2a_decode: scancode remap and key map lookup, combinational.
// Depends on sc2a_pkg.
module sc2a_decode (
    input  logic [sc2a_pkg::CODE_W-1:0] scancode,
    output logic [sc2a_pkg::CHAR_W-1:0] character
);

    logic [sc2a_pkg::CODE_W-1:0] code;

    always_comb
    begin
        code = scancode;
        if (scancode == sc2a_pkg::CODE_KP_ALT_A)
        begin
            code = sc2a_pkg::CODE_SPACE;
        end
        else if (scancode == sc2a_pkg::CODE_KP_ALT_B)
        begin
            code = sc2a_pkg::CODE_SLASH_KEY;
        end

        if (code == sc2a_pkg::CODE_ENTER)
        begin
            character = sc2a_pkg::CHAR_NEWLINE;
        end
        else if (code == sc2a_pkg::CODE_BACKSPACE)
        begin
            character = sc2a_pkg::CHAR_BACKSPACE;
        end
        else
        begin
            character = sc2a_pkg::key_lookup(code);
        end
    end

endmodule

// ----- hdl/sc2a_ring.sv -----
// sc2a_ring: character ring memory with write and read pointers.
// Synchronous memory with a registered read port. Depends on sc2a_pkg.
module sc2a_ring #(
    parameter int unsigned RING_DEPTH = sc2a_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sc2a_pkg::ring_ctrl_t        ctrl,
    input  logic [sc2a_pkg::CHAR_W-1:0] push_char,
    output sc2a_pkg::ring_stat_t        stat,
    output logic [sc2a_pkg::CHAR_W-1:0] pop_char
);

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [sc2a_pkg::CHAR_W-1:0] mem [RING_DEPTH];
    logic [sc2a_pkg::CHAR_W-1:0] q_reg;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    // wrap at the depth, not at the power of two
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.full  = (wr_ptr_inc == rd_ptr_reg);
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);

    assign wr_ptr_next = ctrl.push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = ctrl.pop  ? rd_ptr_inc : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= push_char;
        end
        if (ctrl.pop)
        begin
            q_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_char = q_reg;

endmodule

// ----- hdl/scancode_to_ascii_fifo.sv -----
// scancode_to_ascii_fifo: top level, set-1 scancodes to ASCII in a ring buffer.
// Depends on sc2a_pkg, sc2a_decode, sc2a_ring.
//
// Channel   Ports                    Handshake
// -------   ----------------------   --------------------------------------
// command   command (command_t)      taken when start && !busy
// result    result (result_t)        result_valid strobe, one cycle, no stall
//
// Every item gives exactly one result, in the cycle after it is taken; one item
// can be taken every cycle. A read's character comes from the ring memory's
// registered read port, which delivers it in the cycle after the item. rst_n is
// asynchronous and clears both ring pointers and the result strobe; memory
// contents are left as they are. The receiver cannot stall, so busy stays low.
module scancode_to_ascii_fifo #(
    parameter int unsigned RING_DEPTH = sc2a_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sc2a_pkg::command_t  command,
    output logic                result_valid,
    output sc2a_pkg::result_t   result
);

    logic                        accept;
    logic [sc2a_pkg::CHAR_W-1:0] dec_char;
    sc2a_pkg::ring_ctrl_t        ring_ctrl;
    sc2a_pkg::ring_stat_t        ring_stat;
    logic [sc2a_pkg::CHAR_W-1:0] pop_char;

    logic                          valid_reg;
    logic                          valid_next;
    logic                          from_mem_reg;
    logic                          from_mem_next;
    logic [sc2a_pkg::STATUS_W-1:0] status_reg;
    logic [sc2a_pkg::STATUS_W-1:0] status_next;
    logic [sc2a_pkg::CHAR_W-1:0]   char_reg;
    logic [sc2a_pkg::CHAR_W-1:0]   char_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    sc2a_decode u_decode (
        .scancode  (command.scancode),
        .character (dec_char)
    );

    sc2a_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ring_ctrl),
        .push_char (dec_char),
        .stat      (ring_stat),
        .pop_char  (pop_char)
    );

    // Decide the outcome at accept; pointers move in the same cycle, so the
    // next item already sees the updated full/empty flags.
    always_comb
    begin
        ring_ctrl     = '0;
        valid_next    = accept;
        from_mem_next = 1'b0;
        status_next   = status_reg;
        char_next     = sc2a_pkg::CHAR_NONE;
        if (accept)
        begin
            if (command.operation == sc2a_pkg::OP_SCANCODE)
            begin
                if (dec_char == sc2a_pkg::CHAR_NONE)
                begin
                    status_next = sc2a_pkg::ST_IGNORED;
                end
                else if (ring_stat.full)
                begin
                    status_next = sc2a_pkg::ST_DROPPED;
                end
                else
                begin
                    ring_ctrl.push = 1'b1;
                    status_next    = sc2a_pkg::ST_STORED;
                    char_next      = dec_char;
                end
            end
            else
            begin
                if (ring_stat.empty)
                begin
                    status_next = sc2a_pkg::ST_READ_EMPTY;
                end
                else
                begin
                    ring_ctrl.pop = 1'b1;
                    from_mem_next = 1'b1;
                    status_next   = sc2a_pkg::ST_READ_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            from_mem_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        char_reg   <= char_next;
    end

    // popped character comes straight off the memory read register
    assign result_valid     = valid_reg;
    assign result.status    = status_reg;
    assign result.character = from_mem_reg ? pop_char : char_reg;

endmodule

// ----- test/scancode_to_ascii_fifo_test.sv -----
// scancode_to_ascii_fifo_test: self-checking bench for the scancode-to-ASCII ring.
// Drives directed and random scancode/read items and checks every result strobe
// against its own key map and ring predictor. Depends on sc2a_pkg and the DUT.
module scancode_to_ascii_fifo_test;

    localparam int DEPTH       = sc2a_pkg::RING_DEPTH_DEFAULT;
    localparam int KEYMAP_LEN  = 76;
    // ~700 items with gaps between bursts stay well under this limit
    localparam int CYCLE_LIMIT = 100000;

    // Set-1 lower-case key map, index = scancode. Entries past the end are zero.
    localparam logic [6:0] KEYMAP [0:KEYMAP_LEN-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,   // 0x00..0x07
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,   // 0x08..0x0F
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,   // 0x10..0x17
        7'h6F, 7'h70, 7'h00, 7'h5B, 7'h00, 7'h00, 7'h61, 7'h73,   // 0x18..0x1F
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,   // 0x20..0x27
        7'h00, 7'h5D, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,   // 0x28..0x2F
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h3B, 7'h00, 7'h00,   // 0x30..0x37
        7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,   // 0x38..0x3F
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,   // 0x40..0x47
        7'h00, 7'h00, 7'h00, 7'h00                                // 0x48..0x4B
    };

    // Random traffic shapes: mixed, mostly keystrokes (runs into full),
    // mostly reads (runs into empty).
    typedef enum int { PH_MIX, PH_FILL, PH_DRAIN } phase_t;

    typedef struct {
        sc2a_pkg::command_t cmd;
        bit                 typed;      // expected result written into the table
        sc2a_pkg::result_t  want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    sc2a_pkg::command_t command;
    logic               result_valid;
    sc2a_pkg::result_t  result;

    // Travel alongside command so the checker sees the typed expectation
    // at the same edge the item is taken.
    logic               hint_typed;
    sc2a_pkg::result_t  hint_want;

    // Predictor state: its own copy of the ring and both pointers.
    logic [6:0] ring_chars [DEPTH];
    int         wr_ptr;
    int         rd_ptr;

    sc2a_pkg::result_t replies_due [$];
    dir_row_t          directed [$];
    int                mismatches;
    int                burst_left;
    int                cycles;

    scancode_to_ascii_fifo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run-away guard. Counts every cycle, reset included.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("scancode_to_ascii_fifo_test NOT OK");
            $finish;
        end
    end

    // Scancode to character: the two keypad aliases are folded first, then
    // enter and backspace, then the table. Anything at or past the table end,
    // including every code with bit 7 set, gives no character.
    function automatic logic [6:0] key_char(logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c == sc2a_pkg::CODE_KP_ALT_A)
            c = sc2a_pkg::CODE_SPACE;
        if (c == sc2a_pkg::CODE_KP_ALT_B)
            c = sc2a_pkg::CODE_SLASH_KEY;
        if (c == sc2a_pkg::CODE_ENTER)
            return sc2a_pkg::CHAR_NEWLINE;
        if (c == sc2a_pkg::CODE_BACKSPACE)
            return sc2a_pkg::CHAR_BACKSPACE;
        if (c < KEYMAP_LEN)
            return KEYMAP[c];
        return sc2a_pkg::CHAR_NONE;
    endfunction

    // One item through the ring. The ring keeps one slot free, so it is full
    // when the write pointer sits just behind the read pointer.
    function automatic sc2a_pkg::result_t advance_ring(sc2a_pkg::command_t cmd);
        sc2a_pkg::result_t r;
        logic [6:0]        ch;
        int                nxt;
        r.status    = sc2a_pkg::ST_IGNORED;
        r.character = sc2a_pkg::CHAR_NONE;
        if (cmd.operation == sc2a_pkg::OP_SCANCODE)
        begin
            ch = key_char(cmd.scancode);
            if (ch != sc2a_pkg::CHAR_NONE)
            begin
                nxt = (wr_ptr + 1) % DEPTH;
                if (nxt == rd_ptr)
                    r.status = sc2a_pkg::ST_DROPPED;
                else
                begin
                    ring_chars[wr_ptr] = ch;
                    wr_ptr             = nxt;
                    r.status           = sc2a_pkg::ST_STORED;
                    r.character        = ch;
                end
            end
        end
        else if (wr_ptr == rd_ptr)
            r.status = sc2a_pkg::ST_READ_EMPTY;
        else
        begin
            // scancode field is don't-care on a read
            r.character = ring_chars[rd_ptr];
            rd_ptr      = (rd_ptr + 1) % DEPTH;
            r.status    = sc2a_pkg::ST_READ_OK;
        end
        return r;
    endfunction

    // A code that maps to a character, enter, backspace and the slash-key alias included.
    function automatic logic [7:0] printable_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, int'(sc2a_pkg::CODE_KP_ALT_B)));
        while (key_char(c) == sc2a_pkg::CHAR_NONE);
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0d] mismatch on %s: got %0h, expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Checker. Sampled at the clock edge, so all values are pre-edge. The item
    // taken at this edge is queued before the strobe is matched, which keeps the
    // check correct whatever the latency is.
    always @(posedge clk)
    begin : check_results
        sc2a_pkg::result_t due;
        sc2a_pkg::result_t oldest;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                due = advance_ring(command);
                if (hint_typed)
                    due = hint_want;
                replies_due.push_back(due);
            end
            if (result_valid)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("unexpected strobe", int'(result), 0);
                else
                begin
                    oldest = replies_due.pop_front();
                    if (result.status != oldest.status)
                        report_mismatch("status", int'(result.status),
                                        int'(oldest.status));
                    if (result.character != oldest.character)
                        report_mismatch("character", int'(result.character),
                                        int'(oldest.character));
                end
            end
        end
    end

    // Sender. Items go out in bursts of random length; between bursts start
    // drops for a random number of cycles, and a third of the time there is no
    // gap at all. Returns on the edge that takes the item.
    task automatic send_item(sc2a_pkg::command_t cmd, bit typed, sc2a_pkg::result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        start      <= 1'b1;
        command    <= cmd;
        hint_typed <= typed;
        hint_want  <= want;
        burst_left--;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic add_row(logic op, logic [7:0] code, bit typed,
                           logic [2:0] st, logic [6:0] ch);
        dir_row_t row;
        row.cmd.operation   = op;
        row.cmd.scancode    = code;
        row.typed           = typed;
        row.want.status     = st;
        row.want.character  = ch;
        directed.push_back(row);
    endtask

    task automatic run_phase(phase_t kind, int count);
        sc2a_pkg::command_t cmd;
        int                 roll;
        for (int i = 0; i < count; i++)
        begin
            roll          = $urandom_range(0, 99);
            cmd.scancode  = 8'($urandom_range(0, 255));
            cmd.operation = sc2a_pkg::OP_SCANCODE;
            case (kind)
                PH_MIX:
                begin
                    if (roll < 45)
                        cmd.operation = sc2a_pkg::OP_READ;
                    else if (roll < 75)
                        cmd.scancode = printable_code();
                end
                PH_FILL:
                begin
                    // mostly real keystrokes, a little noise
                    if (roll < 95)
                        cmd.scancode = printable_code();
                    else if (roll >= 98)
                        cmd.operation = sc2a_pkg::OP_READ;
                end
                default:
                begin
                    if (roll < 95)
                        cmd.operation = sc2a_pkg::OP_READ;
                end
            endcase
            send_item(cmd, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= '0;
        hint_typed <= 1'b0;
        hint_want  <= '0;
        wr_ptr      = 0;
        rd_ptr      = 0;
        mismatches  = 0;
        burst_left  = 0;
        cycles      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: op, scancode, typed?, status, character
        add_row(sc2a_pkg::OP_READ, 8'hFF, 1'b1,
                sc2a_pkg::ST_READ_EMPTY, sc2a_pkg::CHAR_NONE);   // read right after reset
        add_row(sc2a_pkg::OP_SCANCODE, 8'h00, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);
        add_row(sc2a_pkg::OP_SCANCODE, 8'hFF, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // top of range
        add_row(sc2a_pkg::OP_SCANCODE, 8'h80, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // first code past 127
        add_row(sc2a_pkg::OP_SCANCODE, 8'h7F, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // past the map
        add_row(sc2a_pkg::OP_SCANCODE, 8'h4C, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // first index past map
        add_row(sc2a_pkg::OP_SCANCODE, 8'h4B, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // last map entry, zero
        add_row(sc2a_pkg::OP_SCANCODE, sc2a_pkg::CODE_ENTER, 1'b1,
                sc2a_pkg::ST_STORED, sc2a_pkg::CHAR_NEWLINE);
        add_row(sc2a_pkg::OP_SCANCODE, sc2a_pkg::CODE_BACKSPACE, 1'b1,
                sc2a_pkg::ST_STORED, sc2a_pkg::CHAR_BACKSPACE);
        add_row(sc2a_pkg::OP_SCANCODE, sc2a_pkg::CODE_KP_ALT_A, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);      // folds to an empty slot
        add_row(sc2a_pkg::OP_SCANCODE, sc2a_pkg::CODE_KP_ALT_B, 1'b1,
                sc2a_pkg::ST_STORED, 7'h3B);                     // folds to ';'
        add_row(sc2a_pkg::OP_SCANCODE, 8'h02, 1'b1,
                sc2a_pkg::ST_STORED, 7'h31);
        add_row(sc2a_pkg::OP_SCANCODE, 8'h39, 1'b1,
                sc2a_pkg::ST_IGNORED, sc2a_pkg::CHAR_NONE);
        add_row(sc2a_pkg::OP_SCANCODE, 8'h38, 1'b1,
                sc2a_pkg::ST_STORED, 7'h20);
        // reads with the unused scancode field at both extremes
        add_row(sc2a_pkg::OP_READ, sc2a_pkg::CODE_ENTER, 1'b1,
                sc2a_pkg::ST_READ_OK, sc2a_pkg::CHAR_NEWLINE);
        add_row(sc2a_pkg::OP_READ, 8'h00, 1'b1,
                sc2a_pkg::ST_READ_OK, sc2a_pkg::CHAR_BACKSPACE);
        add_row(sc2a_pkg::OP_READ, 8'hFF, 1'b1,
                sc2a_pkg::ST_READ_OK, 7'h3B);
        add_row(sc2a_pkg::OP_READ, 8'h55, 1'b1,
                sc2a_pkg::ST_READ_OK, 7'h31);
        add_row(sc2a_pkg::OP_READ, 8'hAA, 1'b1,
                sc2a_pkg::ST_READ_OK, 7'h20);
        add_row(sc2a_pkg::OP_READ, 8'h00, 1'b1,
                sc2a_pkg::ST_READ_EMPTY, sc2a_pkg::CHAR_NONE);   // drained again
        add_row(sc2a_pkg::OP_SCANCODE, 8'h10, 1'b0,
                sc2a_pkg::ST_STORED, sc2a_pkg::CHAR_NONE);
        add_row(sc2a_pkg::OP_SCANCODE, 8'h35, 1'b0,
                sc2a_pkg::ST_STORED, sc2a_pkg::CHAR_NONE);
        add_row(sc2a_pkg::OP_SCANCODE, 8'h2B, 1'b0,
                sc2a_pkg::ST_STORED, sc2a_pkg::CHAR_NONE);
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].typed, directed[i].want);

        // Random: fill runs well past 255 stored to hit the full ring,
        // drain runs past the bottom to hit empty reads.
        run_phase(PH_MIX,   60);
        run_phase(PH_FILL,  300);
        run_phase(PH_DRAIN, 280);
        run_phase(PH_MIX,   40);
        start <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        // a few more edges catch any stray strobe
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("scancode_to_ascii_fifo_test OK");
        else
            $display("scancode_to_ascii_fifo_test NOT OK");
        $finish;
    end

endmodule
